@@ rtl/core/dmc_pkg.sv @@
`default_nettype none
package dmc_pkg;

    localparam int ADDR_W   = 16;
    localparam int LEVEL_W  = 7;
    localparam int COUNT_W  = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [ADDR_W-1:0]  UPPER_HALF   = 16'h8000;
    localparam logic [ADDR_W-1:0]  START_RESET  = 16'hC000;
    localparam logic [COUNT_W-1:0] LENGTH_RESET = 12'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP    = 7'd125;
    localparam logic [LEVEL_W-1:0] LEVEL_STEP   = 7'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_INDEX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_ENABLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LENGTH = 3'd4;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef struct packed {
        logic [3:0]         rate_index;
        logic               loop_enable;
        logic               irq_enable;
        logic [ADDR_W-1:0]  start_addr;
        logic [COUNT_W-1:0] sample_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0]         rate_timer;
        logic [LEVEL_W-1:0] level;
        logic [7:0]         shifter;
        logic [2:0]         bit_count;
        logic               silenced;
        logic [7:0]         byte_buffer;
        logic [ADDR_W-1:0]  cur_addr;
        logic [COUNT_W-1:0] bytes_left;
        logic               irq_latch;
    } t_state;

    // Timer reload: half of each rate table period.
    function automatic logic [7:0] rate_half(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'd214;
            4'd1:    r = 8'd190;
            4'd2:    r = 8'd170;
            4'd3:    r = 8'd160;
            4'd4:    r = 8'd143;
            4'd5:    r = 8'd127;
            4'd6:    r = 8'd113;
            4'd7:    r = 8'd107;
            4'd8:    r = 8'd95;
            4'd9:    r = 8'd80;
            4'd10:   r = 8'd71;
            4'd11:   r = 8'd64;
            4'd12:   r = 8'd53;
            4'd13:   r = 8'd42;
            4'd14:   r = 8'd36;
            default: r = 8'd27;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/delta_modulation_sample_channel.sv @@
`default_nettype none
// Delta-modulation sample channel.
// Path: an accepted item goes to the input register, then on to the result register.
// Throughput: one item per cycle when not stalled; input and result register each hold
// one item, so a stalled result still lets one more item into an empty input register.
// Reset (synchronous, active low): channel state and config to their defaults, both
// stages empty.
module delta_modulation_sample_channel (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output      logic                               o_in_ready,
    input  wire logic                               i_kind,
    input  wire logic [7:0]                         i_mem_data,
    output      logic                               o_out_valid,
    input  wire logic                               i_out_ready,
    output      logic [dmc_pkg::LEVEL_W-1:0]        o_dac_level,
    output      logic [dmc_pkg::ADDR_W-1:0]         o_fetch_addr,
    output      logic                               o_irq_pending,
    output      logic                               o_active,
    input  wire logic                               i_cfg_we,
    input  wire logic [dmc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [dmc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dmc_pkg::*;

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;

    logic       r_in_vld;
    logic       r_in_kind;
    logic [7:0] r_in_data;
    logic       r_out_vld;
    logic [LEVEL_W-1:0] r_out_level;
    logic [ADDR_W-1:0]  r_out_addr;
    logic       r_out_irq;
    logic       r_out_active;
    logic       advance;
    logic       in_xfer;

    dmc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dmc_step u_step (
        .i_cfg      (cfg),
        .i_state    (r_state),
        .i_kind     (r_in_kind),
        .i_mem_data (r_in_data),
        .o_state    (n_state)
    );

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state.rate_timer  <= '0;
            r_state.level       <= '0;
            r_state.shifter     <= '0;
            r_state.bit_count   <= '0;
            r_state.silenced    <= 1'b1;
            r_state.byte_buffer <= '0;
            r_state.cur_addr    <= START_RESET;
            r_state.bytes_left  <= '0;
            r_state.irq_latch   <= 1'b0;
        end else begin
            r_in_vld <= in_xfer || (r_in_vld && !advance);
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_kind <= i_kind;
            r_in_data <= i_mem_data;
        end
        if (advance) begin
            r_out_level  <= n_state.level;
            r_out_addr   <= n_state.cur_addr;
            r_out_irq    <= n_state.irq_latch;
            r_out_active <= (n_state.bytes_left != '0);
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_dac_level    = r_out_level;
    assign o_fetch_addr   = r_out_addr;
    assign o_irq_pending  = r_out_irq;
    assign o_active       = r_out_active;

endmodule
`default_nettype wire

@@ rtl/core/dmc_cfg.sv @@
`default_nettype none
module dmc_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [dmc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [dmc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output dmc_pkg::t_cfg                        o_cfg
);
    import dmc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RATE_INDEX:    n_cfg.rate_index    = i_cfg_data[3:0];
                CFG_LOOP_ENABLE:   n_cfg.loop_enable   = i_cfg_data[0];
                CFG_IRQ_ENABLE:    n_cfg.irq_enable    = i_cfg_data[0];
                CFG_START_ADDR:    n_cfg.start_addr    = i_cfg_data;
                CFG_SAMPLE_LENGTH: n_cfg.sample_length = i_cfg_data[COUNT_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_index    <= '0;
            r_cfg.loop_enable   <= 1'b0;
            r_cfg.irq_enable    <= 1'b0;
            r_cfg.start_addr    <= START_RESET;
            r_cfg.sample_length <= LENGTH_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

@@ rtl/core/dmc_step.sv @@
`default_nettype none
module dmc_step (
    input  dmc_pkg::t_cfg    i_cfg,
    input  dmc_pkg::t_state  i_state,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_mem_data,
    output dmc_pkg::t_state  o_state
);
    import dmc_pkg::*;

    logic [COUNT_W-1:0] left_dec;

    assign left_dec = i_state.bytes_left - 1'b1;

    always_comb begin
        o_state = i_state;
        if (i_kind == KIND_RESTART) begin
            if (i_state.bytes_left == '0) begin
                o_state.cur_addr   = i_cfg.start_addr | UPPER_HALF;
                o_state.bytes_left = i_cfg.sample_length;
            end
        end else if (i_state.rate_timer != 8'd0) begin
            o_state.rate_timer = i_state.rate_timer - 8'd1;
        end else begin
            o_state.rate_timer = rate_half(i_cfg.rate_index);
            if (!i_state.silenced) begin
                if (i_state.shifter[0]) begin
                    if (i_state.level <= LEVEL_TOP)
                        o_state.level = i_state.level + LEVEL_STEP;
                end else begin
                    if (i_state.level >= LEVEL_STEP)
                        o_state.level = i_state.level - LEVEL_STEP;
                end
            end
            o_state.shifter = {1'b0, i_state.shifter[7:1]};
            if (i_state.bit_count != 3'd0) begin
                o_state.bit_count = i_state.bit_count - 3'd1;
            end else begin
                o_state.shifter   = i_state.byte_buffer;
                o_state.bit_count = 3'd7;
                if (i_state.bytes_left == '0) begin
                    o_state.byte_buffer = 8'd0;
                end else begin
                    o_state.byte_buffer = i_mem_data;
                    o_state.cur_addr    = (i_state.cur_addr + 1'b1) | UPPER_HALF;
                    o_state.bytes_left  = left_dec;
                    if (left_dec == '0) begin
                        if (i_cfg.loop_enable) begin
                            o_state.cur_addr   = i_cfg.start_addr | UPPER_HALF;
                            o_state.bytes_left = i_cfg.sample_length;
                        end else if (i_cfg.irq_enable) begin
                            o_state.irq_latch = 1'b1;
                        end
                    end
                end
                o_state.silenced = (o_state.bytes_left == '0);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/dmc_checker.sv @@
`default_nettype none
module dmc_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_ready,
    input wire logic                               i_kind,
    input wire logic [7:0]                         i_mem_data,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_ready,
    input wire logic [dmc_pkg::LEVEL_W-1:0]        o_dac_level,
    input wire logic [dmc_pkg::ADDR_W-1:0]         o_fetch_addr,
    input wire logic                               o_irq_pending,
    input wire logic                               o_active,
    input wire logic                               i_cfg_we,
    input wire logic [dmc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input wire logic [dmc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_dac_level)
            && $stable(o_fetch_addr) && $stable(o_irq_pending) && $stable(o_active))
        else $error("result changed while stalled");

    // after reset both stages are empty
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_ready && !o_out_valid)
        else $error("pipeline not empty after reset");

    // level moves in steps of two from zero
    a_level_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_dac_level[0])
        else $error("odd output level");

    a_addr_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_fetch_addr[15])
        else $error("fetch address in lower half");

    // interrupt flag is sticky
    a_irq_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_irq_pending |=> !o_out_valid || o_irq_pending)
        else $error("interrupt flag cleared");

endmodule

bind delta_modulation_sample_channel dmc_checker u_dmc_checker (.*);
`default_nettype wire
